@@ src/kls_pkg.sv @@
// shared constants, types and helpers of the k-th largest stream tracker
package kls_pkg;

	localparam int K_MAX = 16;
	localparam int VAL_W = 32;
	localparam int CNT_W = $clog2(K_MAX + 1);
	localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int RANK_W = 5;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [RANK_W-1:0] rank_t;

	typedef struct packed {
		val_t kth;
		cnt_t held;
		logic full;
	} result_t;

	// rank of zero acts as one, ranks above the store depth saturate
	function automatic cnt_t eff_k(input rank_t rank);
		cnt_t k;
		if (rank == '0) begin
			k = CNT_W'(1);
		end else if (32'(rank) > K_MAX) begin
			k = CNT_W'(K_MAX);
		end else begin
			k = CNT_W'(rank);
		end
		return k;
	endfunction

endpackage

@@ src/kls_store.sv @@
// sorted store of retained values with parallel insert and truncate
module kls_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            update,
	input  kls_pkg::val_t   value,
	input  kls_pkg::cnt_t   k,
	output kls_pkg::result_t result
);
	import kls_pkg::*;

	// entries kept largest first, so dropping the smallest is a truncation
	val_t vals_q [K_MAX];
	cnt_t count_q;

	logic [K_MAX-1:0] ge;
	val_t ext [K_MAX];
	cnt_t n1;
	cnt_t new_n;
	logic [IDX_W-1:0] kth_idx;

	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (vals_q[i] >= value);
		end
		ext[0] = ge[0] ? vals_q[0] : value;
		for (int i = 1; i < K_MAX; i++) begin
			if (ge[i]) begin
				ext[i] = vals_q[i];
			end else if (ge[i-1]) begin
				ext[i] = value;
			end else begin
				ext[i] = vals_q[i-1];
			end
		end
		n1 = count_q + CNT_W'(1);
		new_n = (n1 > k) ? k : n1;
		kth_idx = IDX_W'(new_n - CNT_W'(1));
		result.kth = ext[kth_idx];
		result.held = new_n;
		result.full = (new_n == k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (update) begin
			count_q <= new_n;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			for (int i = 0; i < K_MAX; i++) begin
				vals_q[i] <= ext[i];
			end
		end
	end

endmodule

@@ src/kth_largest_stream_tracker_unit.sv @@
// top level of the streaming k-th largest tracker
//
// usage:
//   input channel (in_valid, in_stall, value) carries one signed word per
//   accepted item; an item is taken at a clock edge with in_valid high and
//   in_stall low
//   output channel (out_valid, out_stall, kth_value, held_count, store_full)
//   returns one result word per input word, in order
//   config channel (cfg_valid, cfg_ready, cfg_data) writes rank_k; ready is
//   always high, write only while no word is in flight
// pipeline: out_valid rises when a word moves from the input register into
//   the result register; throughput one word per cycle while out_stall is
//   low, set by the parallel compare and insert into the sorted store
// reset: arst_n clears the held count, rank_k returns to one and both
//   stages empty; store contents are don't-care until written
// stall: while out_stall holds a pending result, the input stage keeps its
//   word and raises in_stall; once the output register frees, the input
//   stage drains into it and a new word is taken in the same cycle
module kth_largest_stream_tracker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  kls_pkg::val_t             value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output kls_pkg::val_t             kth_value,
	output kls_pkg::cnt_t             held_count,
	output logic                      store_full,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [kls_pkg::RANK_W-1:0] cfg_data
);
	import kls_pkg::*;

	// configuration
	rank_t rank_q;

	// input stage
	logic valid_s1;
	val_t value_s1;

	// result stage
	logic    out_valid_q;
	result_t result_q;

	result_t store_res;
	logic    adv;
	logic    in_accept;

	// the input word moves on when the result register is empty or drains
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_s1 <= value;
		end
	end

	// store updates exactly once per word, when it enters the result register
	kls_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.update (adv),
		.value  (value_s1),
		.k      (eff_k(rank_q)),
		.result (store_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= store_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kth_value  = result_q.kth;
	assign held_count = result_q.held;
	assign store_full = result_q.full;

`ifndef ASSERT_OFF
	// a delivered result always holds between one and the store depth
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (held_count != '0) && (32'(held_count) <= K_MAX))
		else $error("held count out of range");

	// input backpressure only comes from a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a word leaving the input stage always shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("result lost after input stage advanced");
`endif

endmodule
